FILE: hdl/mpeg_start_code_stats_macros.svh
// Assertion macros shared by the start code scanner RTL.
`ifndef MPEG_START_CODE_STATS_MACROS_SVH
`define MPEG_START_CODE_STATS_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define MSCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define MSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mscs_pkg.sv
// Package with the constants shared by the start code scanner.
package mscs_pkg;

    localparam int BYTE_W          = 8;
    localparam int OUT_W           = 32;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int NUM_CODES       = 4;
    localparam int NUM_RESULTS     = 6;
    localparam int OUT_TDATA_W     = 200;
    localparam int HIST_W          = 3 * BYTE_W;

    localparam logic [BYTE_W-1:0] CODE_PACK     = 8'hBA;
    localparam logic [BYTE_W-1:0] CODE_SYSTEM   = 8'hBB;
    localparam logic [BYTE_W-1:0] CODE_SEQUENCE = 8'hB3;
    localparam logic [BYTE_W-1:0] CODE_NAV      = 8'hBF;

    localparam logic [HIST_W-1:0] HIST_RESET     = 24'hFFFFFF;
    localparam logic [HIST_W-1:0] PREFIX_PATTERN = 24'h000001;
    localparam logic [1:0]        HIST_FULL      = 2'd3;

    localparam int IDX_PACK     = 0;
    localparam int IDX_SYSTEM   = 1;
    localparam int IDX_SEQUENCE = 2;
    localparam int IDX_NAV      = 3;

    localparam int RES_BYTES    = 0;
    localparam int RES_ZERO_RUN = 1;
    localparam int RES_CODES    = 2;

    typedef logic [OUT_W-1:0] t_out_word;

endpackage

FILE: hdl/mpeg_start_code_stats.sv
// Start code scanner: counts MPEG program stream start codes over one buffer.
//
// Takes one byte per clock unless stalled: every byte is classified and all
// counters are updated in the cycle it is accepted. On the byte marked with
// tlast, one request carrying the byte count, the longest zero run, the four
// start code counts and the program stream flag is loaded into the output
// register, and all scan state returns to its reset value so the next buffer
// can start with the next accepted byte. A second output register absorbs one
// result while the first waits, so the input only stalls when both are full.
// Counters are COUNT_WIDTH bits and saturate; values beyond 32 bits read out
// as all ones.
module mpeg_start_code_stats
    import mscs_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // data_byte [7:0]
    input  logic [BYTE_W-1:0]      i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // byte_total [31:0], longest_zero_run [63:32], pack_count [95:64],
    // system_header_total [127:96], sequence_header_total [159:128],
    // nav_pack_total [191:160], program_stream_flag [192], zero pad [199:193]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    `include "mpeg_start_code_stats_macros.svh"

    logic [HIST_W-1:0]      r_hist;
    logic [1:0]             r_hist_cnt;
    logic [COUNT_WIDTH-1:0] r_bytes;
    logic [COUNT_WIDTH-1:0] r_cur_run;
    logic [COUNT_WIDTH-1:0] r_best_run;
    logic [COUNT_WIDTH-1:0] r_codes [NUM_CODES];

    logic [HIST_W-1:0]      n_hist;
    logic [1:0]             n_hist_cnt;
    logic [COUNT_WIDTH-1:0] n_bytes;
    logic [COUNT_WIDTH-1:0] n_cur_run;
    logic [COUNT_WIDTH-1:0] n_best_run;
    logic [COUNT_WIDTH-1:0] n_codes [NUM_CODES];

    logic [COUNT_WIDTH-1:0] w_bytes;
    logic [COUNT_WIDTH-1:0] w_cur_run;
    logic [COUNT_WIDTH-1:0] w_best_run;
    logic [COUNT_WIDTH-1:0] w_codes [NUM_CODES];
    logic [NUM_CODES-1:0]   w_hit;
    logic                   w_prefix;

    logic [COUNT_WIDTH-1:0] w_res [NUM_RESULTS];
    t_out_word              w_clamped [NUM_RESULTS];
    logic                   w_likely;
    logic [OUT_TDATA_W-1:0] w_result;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_skid_valid;
    logic [OUT_TDATA_W-1:0] r_skid_data;

    logic w_in_acc;
    logic w_push;
    logic w_pop;

    assign o_s_axis_tready = !r_skid_valid;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_push          = w_in_acc && i_s_axis_tlast;
    assign w_pop           = r_out_valid && i_m_axis_tready;

    assign w_prefix = (r_hist_cnt == HIST_FULL) && (r_hist == PREFIX_PATTERN);

    always_comb begin
        w_hit               = '0;
        w_hit[IDX_PACK]     = w_prefix && (i_s_axis_tdata == CODE_PACK);
        w_hit[IDX_SYSTEM]   = w_prefix && (i_s_axis_tdata == CODE_SYSTEM);
        w_hit[IDX_SEQUENCE] = w_prefix && (i_s_axis_tdata == CODE_SEQUENCE);
        w_hit[IDX_NAV]      = w_prefix && (i_s_axis_tdata == CODE_NAV);
    end

    always_comb begin
        w_bytes = (&r_bytes) ? r_bytes : r_bytes + COUNT_WIDTH'(1);
        if (i_s_axis_tdata == '0) begin
            w_cur_run = (&r_cur_run) ? r_cur_run : r_cur_run + COUNT_WIDTH'(1);
        end else begin
            w_cur_run = '0;
        end
        w_best_run = (w_cur_run > r_best_run) ? w_cur_run : r_best_run;
        for (int k = 0; k < NUM_CODES; k++) begin
            if (w_hit[k] && !(&r_codes[k])) begin
                w_codes[k] = r_codes[k] + COUNT_WIDTH'(1);
            end else begin
                w_codes[k] = r_codes[k];
            end
        end
    end

    always_comb begin
        if (i_s_axis_tlast) begin
            n_hist     = HIST_RESET;
            n_hist_cnt = '0;
            n_bytes    = '0;
            n_cur_run  = '0;
            n_best_run = '0;
            for (int k = 0; k < NUM_CODES; k++) begin
                n_codes[k] = '0;
            end
        end else begin
            n_hist     = {r_hist[HIST_W-BYTE_W-1:0], i_s_axis_tdata};
            n_hist_cnt = (r_hist_cnt == HIST_FULL) ? r_hist_cnt : r_hist_cnt + 2'd1;
            n_bytes    = w_bytes;
            n_cur_run  = w_cur_run;
            n_best_run = w_best_run;
            for (int k = 0; k < NUM_CODES; k++) begin
                n_codes[k] = w_codes[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= HIST_RESET;
            r_hist_cnt <= '0;
            r_bytes    <= '0;
            r_cur_run  <= '0;
            r_best_run <= '0;
            for (int k = 0; k < NUM_CODES; k++) begin
                r_codes[k] <= '0;
            end
        end else if (w_in_acc) begin
            r_hist     <= n_hist;
            r_hist_cnt <= n_hist_cnt;
            r_bytes    <= n_bytes;
            r_cur_run  <= n_cur_run;
            r_best_run <= n_best_run;
            for (int k = 0; k < NUM_CODES; k++) begin
                r_codes[k] <= n_codes[k];
            end
        end
    end

    assign w_res[RES_BYTES]    = w_bytes;
    assign w_res[RES_ZERO_RUN] = w_best_run;

    genvar g;
    generate
        for (g = 0; g < NUM_CODES; g++) begin : g_code_res
            assign w_res[RES_CODES + g] = w_codes[g];
        end
        for (g = 0; g < NUM_RESULTS; g++) begin : g_clamp
            if (COUNT_WIDTH > OUT_W) begin : g_wide
                assign w_clamped[g] = (|w_res[g][COUNT_WIDTH-1:OUT_W]) ? '1
                                                                       : w_res[g][OUT_W-1:0];
            end else begin : g_narrow
                assign w_clamped[g] = OUT_W'(w_res[g]);
            end
        end
    endgenerate

    always_comb begin
        w_likely = 1'b0;
        for (int k = 0; k < NUM_CODES; k++) begin
            w_likely = w_likely || (w_codes[k] != '0);
        end
    end

    assign w_result = {7'd0, w_likely,
                       w_clamped[5], w_clamped[4], w_clamped[3],
                       w_clamped[2], w_clamped[1], w_clamped[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (w_push) begin
                r_out_data <= w_result;
            end
        end else if (w_push) begin
            r_skid_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `MSCS_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "Second output register holds a request while the first is empty.")
    `MSCS_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, w_push,
        (r_bytes == '0) && (r_hist_cnt == '0),
        "Scan state was not cleared after the last byte.")
    `MSCS_ASSERT_NOW(a_run_order, i_clk, i_rst_n, 1'b1,
        (r_cur_run <= r_best_run) && (r_best_run <= r_bytes),
        "Zero run counters are out of order.")
    `MSCS_ASSERT_NOW(a_likely_flag, i_clk, i_rst_n, r_out_valid,
        r_out_data[6*OUT_W] == (|r_out_data[6*OUT_W-1:2*OUT_W]),
        "Program stream flag disagrees with the start code counts.")

endmodule

FILE: tb/sv/mpeg_start_code_stats_tb.sv
// Testbench for the start code scanner: byte buffers in, per-buffer statistics checked.
module mpeg_start_code_stats_tb;
    import mscs_pkg::*;

    localparam int COUNT_W      = COUNT_WIDTH_DEF;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 1600;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_WAIT     = 17;

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic [6:0] pad;
        logic       program_stream;
        t_out_word  nav_packs;
        t_out_word  seq_headers;
        t_out_word  sys_headers;
        t_out_word  packs;
        t_out_word  longest_zeros;
        t_out_word  byte_total;
    } t_stats;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        bit                typed;
        t_stats            want;
    } t_row;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [BYTE_W-1:0]      s_data  = '0;
    logic                   s_last  = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;

    t_count            scan_bytes;
    t_count            scan_zero_now;
    t_count            scan_zero_best;
    t_count            scan_codes [NUM_CODES];
    logic [HIST_W-1:0] scan_hist;
    logic [1:0]        scan_fill;

    t_stats pending_stats[$];
    t_row   dir_rows[$];
    int     mismatch_count = 0;
    int     bytes_sent     = 0;
    int     buffers_sent   = 0;
    int     quiet_cycles   = 0;
    int     feed_mode      = 0;
    int     drain_mode     = 0;

    mpeg_start_code_stats #(
        .COUNT_WIDTH(COUNT_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void clear_scan();
        scan_bytes     = '0;
        scan_zero_now  = '0;
        scan_zero_best = '0;
        for (int k = 0; k < NUM_CODES; k++) scan_codes[k] = '0;
        scan_hist = HIST_RESET;
        scan_fill = '0;
    endfunction

    function automatic t_count sat_inc(t_count v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic t_out_word clip_out(t_count v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_W-1:0];
    endfunction

    // Folds one byte into the running statistics; returns 1 with the buffer
    // summary when the byte closes the buffer.
    function automatic bit scan_byte(input logic [BYTE_W-1:0] b, input logic last,
                                     output t_stats res);
        int code_idx;
        code_idx = -1;
        res = '0;
        scan_bytes = sat_inc(scan_bytes);
        if (b == 8'h00) begin
            scan_zero_now = sat_inc(scan_zero_now);
            if (scan_zero_now > scan_zero_best) scan_zero_best = scan_zero_now;
        end else begin
            scan_zero_now = '0;
        end
        if (scan_fill == HIST_FULL && scan_hist == PREFIX_PATTERN) begin
            case (b)
                CODE_PACK:     code_idx = IDX_PACK;
                CODE_SYSTEM:   code_idx = IDX_SYSTEM;
                CODE_SEQUENCE: code_idx = IDX_SEQUENCE;
                CODE_NAV:      code_idx = IDX_NAV;
                default:       code_idx = -1;
            endcase
            if (code_idx >= 0) scan_codes[code_idx] = sat_inc(scan_codes[code_idx]);
        end
        scan_hist = {scan_hist[HIST_W-BYTE_W-1:0], b};
        if (scan_fill != HIST_FULL) scan_fill = scan_fill + 1'b1;
        if (!last) return 1'b0;
        res.byte_total     = clip_out(scan_bytes);
        res.longest_zeros  = clip_out(scan_zero_best);
        res.packs          = clip_out(scan_codes[IDX_PACK]);
        res.sys_headers    = clip_out(scan_codes[IDX_SYSTEM]);
        res.seq_headers    = clip_out(scan_codes[IDX_SEQUENCE]);
        res.nav_packs      = clip_out(scan_codes[IDX_NAV]);
        res.program_stream = |{scan_codes[IDX_PACK], scan_codes[IDX_SYSTEM],
                               scan_codes[IDX_SEQUENCE], scan_codes[IDX_NAV]};
        clear_scan();
        return 1'b1;
    endfunction

    function automatic t_row mid_byte(logic [BYTE_W-1:0] b);
        t_row r;
        r.data  = b;
        r.last  = 1'b0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row closing_byte(logic [BYTE_W-1:0] b, int unsigned n_bytes,
                                          int unsigned n_zero, int unsigned n_pack,
                                          int unsigned n_sys, int unsigned n_seq,
                                          int unsigned n_nav);
        t_row r;
        r.data                = b;
        r.last                = 1'b1;
        r.typed               = 1'b1;
        r.want                = '0;
        r.want.byte_total     = n_bytes;
        r.want.longest_zeros  = n_zero;
        r.want.packs          = n_pack;
        r.want.sys_headers    = n_sys;
        r.want.seq_headers    = n_seq;
        r.want.nav_packs      = n_nav;
        r.want.program_stream = (n_pack | n_sys | n_seq | n_nav) != 0;
        return r;
    endfunction

    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, MAX_WAIT);
            default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(string name, t_out_word got, t_out_word want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_stats(t_stats got);
        t_stats want;
        if (pending_stats.size() == 0) begin
            flag_mismatch($sformatf("result with nothing pending, byte_total %0d",
                                    got.byte_total));
            return;
        end
        want = pending_stats.pop_front();
        compare_field("byte_total", got.byte_total, want.byte_total);
        compare_field("longest_zero_run", got.longest_zeros, want.longest_zeros);
        compare_field("pack_count", got.packs, want.packs);
        compare_field("system_header_total", got.sys_headers, want.sys_headers);
        compare_field("sequence_header_total", got.seq_headers, want.seq_headers);
        compare_field("nav_pack_total", got.nav_packs, want.nav_packs);
        compare_field("program_stream_flag", 32'(got.program_stream),
                      32'(want.program_stream));
        compare_field("pad", 32'(got.pad), 32'(want.pad));
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b, logic last, bit typed, t_stats want);
        int     gap;
        t_stats res;
        gap = draw_wait(feed_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
        if (scan_byte(b, last, res)) pending_stats.push_back(typed ? want : res);
        bytes_sent++;
    endtask

    task automatic send_random_buffer();
        logic [BYTE_W-1:0] buf_q[$];
        int                len;
        int                pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) len = $urandom_range(1, 24);
        else if (pick < 19) len = $urandom_range(25, 80);
        else len = $urandom_range(150, 400);
        while (buf_q.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1: buf_q.push_back(8'($urandom));
                2: begin
                    if (len > 100 && $urandom_range(0, 2) == 0)
                        repeat ($urandom_range(1, len)) buf_q.push_back(8'h00);
                    else
                        repeat ($urandom_range(1, 6)) buf_q.push_back(8'h00);
                end
                3: repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom_range(0, 1)));
                default: begin
                    buf_q.push_back(8'h00);
                    buf_q.push_back(8'h00);
                    buf_q.push_back(8'h01);
                    case ($urandom_range(0, 5))
                        0: buf_q.push_back(CODE_PACK);
                        1: buf_q.push_back(CODE_SYSTEM);
                        2: buf_q.push_back(CODE_SEQUENCE);
                        3: buf_q.push_back(CODE_NAV);
                        4: buf_q.push_back(8'($urandom));
                        default: ;
                    endcase
                end
            endcase
        end
        while (buf_q.size() > len) void'(buf_q.pop_back());
        for (int i = 0; i < len; i++) send_byte(buf_q[i], i == len - 1, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) drain_mode = $urandom_range(0, 2);
            stall = draw_wait(drain_mode);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            check_stats(t_stats'(m_data));
        end
    end

    initial begin
        clear_scan();
        feed_mode  = $urandom_range(0, 2);
        drain_mode = $urandom_range(0, 2);
        dir_rows = '{
            closing_byte(8'hFF, 1, 0, 0, 0, 0, 0),
            closing_byte(8'h00, 1, 1, 0, 0, 0, 0),
            mid_byte(8'h00), mid_byte(8'h00), mid_byte(8'h01), mid_byte(CODE_PACK),
            mid_byte(8'h00), mid_byte(8'h00), mid_byte(8'h01),
            closing_byte(CODE_SYSTEM, 8, 2, 1, 1, 0, 0),
            mid_byte(8'h00), mid_byte(8'h00), mid_byte(8'h00), mid_byte(8'h01),
            closing_byte(CODE_SEQUENCE, 5, 3, 0, 0, 1, 0),
            mid_byte(8'h00), mid_byte(8'h00),
            closing_byte(8'h01, 3, 2, 0, 0, 0, 0),
            mid_byte(8'h00), mid_byte(8'h00), mid_byte(8'h01), mid_byte(8'hE0),
            mid_byte(8'h00), mid_byte(8'h00), mid_byte(8'h01),
            closing_byte(CODE_NAV, 8, 2, 0, 0, 0, 1)
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            feed_mode = $urandom_range(0, 2);
            send_random_buffer();
            buffers_sent++;
            // Let the output side run dry now and then before feeding more.
            if (buffers_sent == 5 || $urandom_range(0, 14) == 0) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_stats.size() != 0) @(posedge i_clk);
            end
        end
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/mscs_pkg.sv
hdl/mpeg_start_code_stats.sv
tb/sv/mpeg_start_code_stats_tb.sv
